// ===== hdl/abm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package abm_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_LUMA_BITS  = 16;

  localparam int PIX_W   = 16;
  localparam int DIM_W   = 7;
  localparam int ALPHA_W = 16;
  localparam int WARM_W  = 16;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;

  localparam logic [CIDX_W-1:0] CFG_COOL_WEIGHT = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_WARM_WEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_DARK_HOT    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_WARMUP_MIN  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_DIMS_STRICT = 3'd4;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic             refresh_mask;
    logic             start_of_frame;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             scene_cut;
    logic             selective_refresh;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] prior_background;
    logic [PIX_W-1:0] new_background;
    logic             frame_was_reset;
    logic             background_ready;
    logic             last_of_frame;
    logic             overrun;
  } out_item_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] value;
  } cfg_req_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] cool_weight;
    logic [ALPHA_W-1:0] warm_weight;
    logic               dark_hot;
    logic [WARM_W-1:0]  warmup_min;
    logic               dims_strict;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cool_weight: 16'd3277,
    warm_weight: 16'd655,
    dark_hot:    1'b0,
    warmup_min:  16'd10,
    dims_strict: 1'b1
  };

endpackage

`default_nettype wire

// ===== hdl/abm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface abm_in_if;
  logic               valid;
  logic               ready;
  abm_pkg::in_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface abm_out_if;
  logic               valid;
  logic               ready;
  abm_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface abm_cfg_if;
  logic               valid;
  logic               ready;
  abm_pkg::cfg_req_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/abm_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none

module abm_blend #(
  parameter int LUMA_BITS = abm_pkg::DEF_LUMA_BITS
) (
  input  wire abm_pkg::cfg_t        cfg,
  input  wire logic [LUMA_BITS-1:0] bg,
  input  wire logic [LUMA_BITS-1:0] cur,
  output logic      [LUMA_BITS-1:0] nv
);

  localparam int DW = LUMA_BITS + 1;
  localparam int PW = DW + abm_pkg::ALPHA_W + 1;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] delta;
  logic                 cold;
  logic signed [abm_pkg::ALPHA_W:0] alpha;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] sum;

  always_comb begin
    delta = $signed({1'b0, cur}) - $signed({1'b0, bg});
    cold  = cfg.dark_hot ? (delta > 0) : (delta < 0);
    alpha = $signed({1'b0, (cold ? cfg.cool_weight : cfg.warm_weight)});
    prod  = PW'(delta) * PW'(alpha);
    sum   = $signed(SW'({1'b0, bg})) + SW'(prod >>> abm_pkg::ALPHA_W);
    priority if (sum < 0) begin
      nv = '0;
    end else if (sum > $signed(SW'({1'b0, {LUMA_BITS{1'b1}}}))) begin
      nv = '1;
    end else begin
      nv = sum[LUMA_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/asymmetric_background_model_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-pixel thermal background model. Pixels come in row-major order, one
// request per clock unless the output stalls, with start_of_frame on the
// first pixel of each frame. A frame whose size differs from the stored one,
// a scene cut, or a never loaded store makes the frame reload the background;
// otherwise each pixel moves toward the input with an asymmetric running
// average, or keeps its value under selective refresh with a clear mask.
// The single background RAM read is registered, then blended, written back
// with bypass of a same-address write, and registered out. The store needs
// a full reloading frame before it holds valid data; there is no clear pass.
// Configuration writes are accepted at any time and must be made while idle.
module asymmetric_background_model_core #(
  parameter int MAX_WIDTH  = abm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = abm_pkg::DEF_MAX_HEIGHT,
  parameter int LUMA_BITS  = abm_pkg::DEF_LUMA_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  abm_in_if.sink   in_ch,
  abm_out_if.source out_ch,
  abm_cfg_if.sink  cfg_ch
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB    = $clog2(DEPTH + 1);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = abm_pkg::PIX_W;

  function automatic logic [8:0] clamp_dim(logic [abm_pkg::DIM_W-1:0] v, logic [8:0] maxv);
    logic [8:0] ve;
    ve = 9'(v);
    priority if (ve == 9'd0) begin
      return 9'd1;
    end else if (ve > maxv) begin
      return maxv;
    end else begin
      return ve;
    end
  endfunction

  abm_pkg::cfg_t cfg_r;

  logic                        store_valid_r;
  logic [WB-1:0]               stored_w_r;
  logic [HB-1:0]               stored_h_r;
  logic [abm_pkg::WARM_W-1:0]  warmup_r;
  logic [CB-1:0]               pix_cnt_r;
  logic [CB-1:0]               frame_cnt_r;
  logic                        frame_active_r;
  logic                        fl_reload_r;
  logic                        fl_ready_r;
  logic                        fl_sel_r;

  logic                 s1_valid_r;
  logic                 s1_ovr_r;
  logic [AW-1:0]        s1_idx_r;
  logic [LUMA_BITS-1:0] s1_luma_r;
  logic                 s1_mask_r;
  logic                 s1_reload_r;
  logic                 s1_ready_r;
  logic                 s1_sel_r;
  logic                 s1_last_r;

  logic [LUMA_BITS-1:0] mem [DEPTH];
  logic [LUMA_BITS-1:0] rd_data_r;
  logic                 fwd_r;
  logic [LUMA_BITS-1:0] fwd_data_r;

  logic                 out_valid_r;
  abm_pkg::out_item_t   out_data_r;

  abm_pkg::in_item_t    din;
  logic                 accept;
  logic                 s1_adv;
  logic                 s1_wr;
  logic [WB-1:0]        w_c;
  logic [HB-1:0]        h_c;
  logic                 same;
  logic                 ready_c;
  logic                 reload_c;
  logic                 ovr_c;
  logic [CB-1:0]        cnt_cur;
  logic [CB-1:0]        fc_cur;
  logic                 last_c;
  logic [LUMA_BITS-1:0] luma_c;
  logic [LUMA_BITS-1:0] prior;
  logic [LUMA_BITS-1:0] blend_nv;
  logic [LUMA_BITS-1:0] nv;

  assign din          = in_ch.data;
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign s1_wr        = s1_adv && !s1_ovr_r;
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    w_c      = WB'(clamp_dim(din.frame_width, 9'(MAX_WIDTH)));
    h_c      = HB'(clamp_dim(din.frame_height, 9'(MAX_HEIGHT)));
    same     = (stored_w_r == w_c) && (stored_h_r == h_c);
    ready_c  = store_valid_r && !din.scene_cut && (warmup_r >= cfg_r.warmup_min) &&
               (stored_w_r != '0) && (stored_h_r != '0) &&
               (!cfg_r.dims_strict || same);
    reload_c = din.scene_cut || !store_valid_r || !same;
    ovr_c    = !din.start_of_frame && !frame_active_r;
    cnt_cur  = din.start_of_frame ? '0 : pix_cnt_r;
    fc_cur   = din.start_of_frame ? (CB'(w_c) * CB'(h_c)) : frame_cnt_r;
    last_c   = ({1'b0, cnt_cur} + (CB+1)'(1)) >= {1'b0, fc_cur};
    luma_c   = LUMA_BITS'(din.luma);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= abm_pkg::CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        abm_pkg::CFG_COOL_WEIGHT: cfg_r.cool_weight <= cfg_ch.data.value;
        abm_pkg::CFG_WARM_WEIGHT: cfg_r.warm_weight <= cfg_ch.data.value;
        abm_pkg::CFG_DARK_HOT:    cfg_r.dark_hot <= cfg_ch.data.value[0];
        abm_pkg::CFG_WARMUP_MIN:  cfg_r.warmup_min <= cfg_ch.data.value;
        abm_pkg::CFG_DIMS_STRICT: cfg_r.dims_strict <= cfg_ch.data.value[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_valid_r  <= 1'b0;
      stored_w_r     <= '0;
      stored_h_r     <= '0;
      warmup_r       <= '0;
      pix_cnt_r      <= '0;
      frame_cnt_r    <= '0;
      frame_active_r <= 1'b0;
      fl_reload_r    <= 1'b0;
      fl_ready_r     <= 1'b0;
      fl_sel_r       <= 1'b0;
    end else if (accept && !ovr_c) begin
      if (din.start_of_frame) begin
        if (reload_c) begin
          store_valid_r <= 1'b1;
          stored_w_r    <= w_c;
          stored_h_r    <= h_c;
          warmup_r      <= '0;
        end else if (warmup_r != '1) begin
          warmup_r <= warmup_r + 1'b1;
        end
        fl_reload_r <= reload_c;
        fl_ready_r  <= ready_c;
        fl_sel_r    <= din.selective_refresh;
        frame_cnt_r <= fc_cur;
      end
      if (last_c) begin
        frame_active_r <= 1'b0;
        pix_cnt_r      <= '0;
      end else begin
        frame_active_r <= 1'b1;
        pix_cnt_r      <= cnt_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= !ovr_c && s1_wr && (s1_idx_r == cnt_cur[AW-1:0]);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ovr_r    <= ovr_c;
      s1_idx_r    <= cnt_cur[AW-1:0];
      s1_luma_r   <= luma_c;
      s1_mask_r   <= din.refresh_mask;
      s1_reload_r <= din.start_of_frame ? reload_c : fl_reload_r;
      s1_ready_r  <= din.start_of_frame ? ready_c : fl_ready_r;
      s1_sel_r    <= din.start_of_frame ? din.selective_refresh : fl_sel_r;
      s1_last_r   <= last_c;
      fwd_data_r  <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_idx_r] <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= mem[cnt_cur[AW-1:0]];
    end
  end

  assign prior = fwd_r ? fwd_data_r : rd_data_r;

  abm_blend #(
    .LUMA_BITS(LUMA_BITS)
  ) u_blend (
    .cfg(cfg_r),
    .bg (prior),
    .cur(s1_luma_r),
    .nv (blend_nv)
  );

  always_comb begin
    priority if (s1_reload_r) begin
      nv = s1_luma_r;
    end else if (s1_sel_r && !s1_mask_r) begin
      nv = prior;
    end else begin
      nv = blend_nv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_ovr_r) begin
        out_data_r.prior_background <= '0;
        out_data_r.new_background   <= '0;
        out_data_r.frame_was_reset  <= 1'b0;
        out_data_r.background_ready <= 1'b0;
        out_data_r.last_of_frame    <= 1'b0;
        out_data_r.overrun          <= 1'b1;
      end else begin
        out_data_r.prior_background <= PW'({{PW{1'b0}}, prior});
        out_data_r.new_background   <= PW'({{PW{1'b0}}, nv});
        out_data_r.frame_was_reset  <= s1_reload_r;
        out_data_r.background_ready <= s1_ready_r;
        out_data_r.last_of_frame    <= s1_last_r;
        out_data_r.overrun          <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
